/* rtl/rars_pkg.sv */
// Package for the range-add / range-sum segment tree.
// Holds sizes, command codes, controller states and the control/status structs.
// No dependencies.
package rars_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int TREE_NODES   = 4096;
    localparam int IDX_W        = 11;
    localparam int NODE_W       = $clog2(TREE_NODES);
    localparam int STACK_DEPTH  = 12;
    localparam int SP_W         = $clog2(STACK_DEPTH);
    localparam int SUM_W        = 64;
    localparam int AMT_W        = 32;

    localparam logic [IDX_W-1:0]  MAX_N       = IDX_W'(MAX_ELEMENTS);
    localparam logic [IDX_W-1:0]  COUNT_RESET = IDX_W'(1024);
    localparam logic [NODE_W-1:0] NODE_LAST   = NODE_W'(TREE_NODES - 1);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTER,
        S_FULL_RD,
        S_FULL_WR,
        S_Q_ACC,
        S_PD_RD,
        S_PD_LAT,
        S_PD_LW,
        S_PD_RW,
        S_AFTER_L,
        S_AFTER_R,
        S_SS_RDL,
        S_SS_RDR,
        S_SS_WR,
        S_POP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SUM_ZERO,
        SUM_ADD,
        SUM_RD,
        SUM_PAIR
    } t_sum_sel;

    typedef enum logic {
        PEND_ZERO,
        PEND_ADD
    } t_pend_sel;

    typedef enum logic [1:0] {
        MSRC_INC,
        MSRC_PEND,
        MSRC_AMT
    } t_msrc;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] pend;
    } t_node;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        t_sum_sel          sum_sel;
        t_pend_sel         pend_sel;
        logic              mul_en;
        t_msrc             mul_src;
        logic [IDX_W-1:0]  mul_cnt;
        logic              hold_load;
        logic              acc_clr;
        logic              acc_add;
        logic              amt_load;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/rars_if.sv */
// Channel interfaces of the range-add / range-sum tree: input, result and configuration.
// Depends on rars_pkg.
interface rars_in_if import rars_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [AMT_W-1:0] amount;
    modport source(output valid, cmd, first_index, last_index, amount, input ready);
    modport sink(input valid, cmd, first_index, last_index, amount, output ready);
endinterface

interface rars_out_if import rars_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] range_sum;
    modport source(output valid, range_sum, input ready);
    modport sink(input valid, range_sum, output ready);
endinterface

interface rars_cfg_if import rars_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

/* rtl/rars_dp.sv */
// Datapath: node memory, split multiplier, accumulator and result register.
// Depends on rars_pkg; driven by rars_ctrl through t_dp_cmd.
module rars_dp import rars_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [AMT_W-1:0] i_amount,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [SUM_W-1:0] o_range_sum,
    output t_dp_stat                o_stat
);

    t_node            r_mem [TREE_NODES];
    t_node            r_rd;
    logic [SUM_W-1:0] r_inc;
    logic [SUM_W-1:0] r_hold;
    logic [SUM_W-1:0] r_acc;
    logic [AMT_W-1:0] r_amount;
    logic [42:0]      r_pl;
    logic [31:0]      r_ph;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;

    logic [SUM_W-1:0] w_op;
    logic [SUM_W-1:0] w_prod;
    t_node            w_wdata;

    always_comb begin
        case (i_cmd.mul_src)
            MSRC_PEND: w_op = r_rd.pend;
            MSRC_AMT:  w_op = {{(SUM_W-AMT_W){r_amount[AMT_W-1]}}, r_amount};
            default:   w_op = r_inc;
        endcase
    end

    assign w_prod = {r_ph, 32'd0} + {21'd0, r_pl};

    always_comb begin
        case (i_cmd.sum_sel)
            SUM_ADD:  w_wdata.sum = r_rd.sum + w_prod;
            SUM_RD:   w_wdata.sum = r_rd.sum;
            SUM_PAIR: w_wdata.sum = r_hold + r_rd.sum;
            default:  w_wdata.sum = '0;
        endcase
        case (i_cmd.pend_sel)
            PEND_ADD: w_wdata.pend = r_rd.pend + r_inc;
            default:  w_wdata.pend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pl  <= 43'(w_op[31:0]) * 43'(i_cmd.mul_cnt);
            r_ph  <= w_op[63:32] * {21'd0, i_cmd.mul_cnt};
            r_inc <= w_op;
        end
        if (i_cmd.hold_load) begin
            r_hold <= r_rd.sum;
        end
        if (i_cmd.amt_load) begin
            r_amount <= i_amount;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_rd.sum;
        end
        if (i_cmd.out_load) begin
            r_out_sum <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_range_sum     = r_out_sum;

endmodule

/* rtl/rars_ctrl.sv */
// Controller: range clipping, tree walk with a frame stack and the state machine.
// Depends on rars_pkg; drives rars_dp through t_dp_cmd.
module rars_ctrl import rars_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_in_cmd,
    input  logic [IDX_W-1:0] i_first_index,
    input  logic [IDX_W-1:0] i_last_index,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_data,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_count;
    logic [NODE_W-1:0] r_clr;
    logic              r_op;
    logic [IDX_W-1:0]  r_a, r_b, r_lo, r_hi;
    logic [NODE_W-1:0] r_id;
    logic [SP_W-1:0]   r_sp;
    logic [IDX_W-1:0]  r_stk_lo [STACK_DEPTH];
    logic [IDX_W-1:0]  r_stk_hi [STACK_DEPTH];
    logic [NODE_W-1:0] r_stk_id [STACK_DEPTH];
    logic              r_stk_ph [STACK_DEPTH];

    logic [IDX_W-1:0]  w_n, w_first, w_last;
    logic              w_empty, w_acc;
    logic [IDX_W:0]    w_lh;
    logic [IDX_W-1:0]  w_mid;
    logic              w_full, w_go_l, w_go_r;
    logic [NODE_W-1:0] w_left, w_right;
    logic [SP_W-1:0]   w_top;

    assign w_n     = (r_count > MAX_N) ? MAX_N : r_count;
    assign w_first = (i_first_index == '0) ? IDX_W'(1) : i_first_index;
    assign w_last  = (i_last_index > w_n) ? w_n : i_last_index;
    assign w_empty = (w_n == '0) || (w_first > w_last);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;

    assign w_lh    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_lh[IDX_W:1];
    assign w_full  = (r_a <= r_lo) && (r_hi <= r_b);
    assign w_go_l  = (r_a <= w_mid);
    assign w_go_r  = (w_mid < r_b);
    assign w_left  = {r_id[NODE_W-2:0], 1'b0};
    assign w_right = {r_id[NODE_W-2:0], 1'b1};
    assign w_top   = r_sp - SP_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == NODE_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    if (!w_empty) n_state = S_ENTER;
                    else if (i_in_cmd == CMD_QUERY) n_state = S_OUT;
                end
            end
            S_ENTER: begin
                if (w_full) n_state = S_FULL_RD;
                else if (r_lo == r_hi) n_state = S_POP;
                else n_state = S_PD_RD;
            end
            S_FULL_RD: n_state = (r_op == CMD_ADD) ? S_FULL_WR : S_Q_ACC;
            S_FULL_WR: n_state = S_POP;
            S_Q_ACC:   n_state = S_POP;
            S_PD_RD:   n_state = S_PD_LAT;
            S_PD_LAT:  n_state = S_PD_LW;
            S_PD_LW:   n_state = S_PD_RW;
            S_PD_RW:   n_state = w_go_l ? S_ENTER : S_AFTER_L;
            S_AFTER_L: n_state = w_go_r ? S_ENTER : S_AFTER_R;
            S_AFTER_R: n_state = (r_op == CMD_ADD) ? S_SS_RDL : S_POP;
            S_SS_RDL:  n_state = S_SS_RDR;
            S_SS_RDR:  n_state = S_SS_WR;
            S_SS_WR:   n_state = S_POP;
            S_POP: begin
                if (r_sp == '0) n_state = (r_op == CMD_QUERY) ? S_OUT : S_IDLE;
                else n_state = r_stk_ph[w_top] ? S_AFTER_R : S_AFTER_L;
            end
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_addr   = r_id;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_addr   = r_id;
        o_cmd.sum_sel   = SUM_ZERO;
        o_cmd.pend_sel  = PEND_ZERO;
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_src   = MSRC_INC;
        o_cmd.mul_cnt   = r_hi - r_lo + IDX_W'(1);
        o_cmd.hold_load = 1'b0;
        o_cmd.acc_clr   = 1'b0;
        o_cmd.acc_add   = 1'b0;
        o_cmd.amt_load  = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_clr;
            end
            S_IDLE: begin
                o_cmd.acc_clr  = w_acc;
                o_cmd.amt_load = w_acc;
            end
            S_FULL_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = MSRC_AMT;
            end
            S_FULL_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.sum_sel  = SUM_ADD;
                o_cmd.pend_sel = PEND_ADD;
            end
            S_Q_ACC: begin
                o_cmd.acc_add = 1'b1;
            end
            S_PD_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_PD_LAT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.sum_sel = SUM_RD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = MSRC_PEND;
                o_cmd.mul_cnt = w_mid - r_lo + IDX_W'(1);
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = w_left;
            end
            S_PD_LW: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = w_left;
                o_cmd.sum_sel  = SUM_ADD;
                o_cmd.pend_sel = PEND_ADD;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_src  = MSRC_INC;
                o_cmd.mul_cnt  = r_hi - w_mid;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr  = w_right;
            end
            S_PD_RW: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = w_right;
                o_cmd.sum_sel  = SUM_ADD;
                o_cmd.pend_sel = PEND_ADD;
            end
            S_SS_RDL: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = w_left;
            end
            S_SS_RDR: begin
                o_cmd.hold_load = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr   = w_right;
            end
            S_SS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.sum_sel = SUM_PAIR;
            end
            S_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= COUNT_RESET;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op <= i_in_cmd;
                        r_a  <= w_first;
                        r_b  <= w_last;
                        r_lo <= IDX_W'(1);
                        r_hi <= w_n;
                        r_id <= NODE_W'(1);
                        r_sp <= '0;
                    end
                end
                S_PD_RW: begin
                    if (w_go_l) begin
                        r_stk_lo[r_sp] <= r_lo;
                        r_stk_hi[r_sp] <= r_hi;
                        r_stk_id[r_sp] <= r_id;
                        r_stk_ph[r_sp] <= 1'b0;
                        r_sp <= r_sp + SP_W'(1);
                        r_hi <= w_mid;
                        r_id <= w_left;
                    end
                end
                S_AFTER_L: begin
                    if (w_go_r) begin
                        r_stk_lo[r_sp] <= r_lo;
                        r_stk_hi[r_sp] <= r_hi;
                        r_stk_id[r_sp] <= r_id;
                        r_stk_ph[r_sp] <= 1'b1;
                        r_sp <= r_sp + SP_W'(1);
                        r_lo <= w_mid + IDX_W'(1);
                        r_id <= w_right;
                    end
                end
                S_POP: begin
                    if (r_sp != '0) begin
                        r_lo <= r_stk_lo[w_top];
                        r_hi <= r_stk_hi[w_top];
                        r_id <= r_stk_id[w_top];
                        r_sp <= w_top;
                    end
                end
                default: begin
                    r_sp <= r_sp;
                end
            endcase
        end
    end

endmodule

/* rtl/range_add_range_sum_tree.sv */
// Top level of the range-add / range-sum segment tree; joins rars_ctrl and rars_dp.
// A new item is accepted only once the tree walk of the last one has ended and the controller is idle.
// A query result loads in S_OUT once the walk ends, waiting there while the last result is held.
// After reset a clearing pass writes all 4096 nodes, with no input accepted.
// Depends on rars_pkg and the channel interfaces in rars_if.
module range_add_range_sum_tree import rars_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rars_in_if.sink i_in,
    rars_out_if.source o_out,
    rars_cfg_if.sink i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rars_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_in_cmd      (i_in.cmd),
        .i_first_index (i_in.first_index),
        .i_last_index  (i_in.last_index),
        .i_cfg_valid   (i_cfg.valid),
        .o_cfg_ready   (i_cfg.ready),
        .i_cfg_data    (i_cfg.data),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    rars_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_amount    (i_in.amount),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_range_sum (o_out.range_sum),
        .o_stat      (w_stat)
    );

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_en && w_cmd.rd_en) |-> (w_cmd.wr_addr != w_cmd.rd_addr))
        else $error("node read and write hit the same address");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result register overwritten while still held");

    a_no_accept_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_en && w_cmd.sum_sel == SUM_ZERO) |-> !i_in.ready)
        else $error("input accepted during the clearing pass");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (o_out.valid && !w_cmd.out_load))
        else $error("result not presented after load");

endmodule
